/* src/bmhpq_pkg.sv */
package bmhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Child index arithmetic needs room for 2 * pos + 2.
  localparam int CHD_W    = IDX_W + 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

/* src/binary_max_heap_priority_queue_unit.sv */
// An insert sifts the new entry up one level at a time, an extract sifts the last entry down from
// the root, and a remove scans one entry at a time for the key, then sifts down (and up if it did
// not move); overflow, underflow and opcode 3 go straight to the result state.
// Throughput: one item at a time, paced by the single compare unit and the two-read, one-write
// heap memory. A new item is taken while a finished result waits to be taken.
// Reset empties the heap (count zero); the heap memory holds no reset value.
module binary_max_heap_priority_queue_unit
  import bmhpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [KEY_BITS-1:0] in_key_in,
  input  logic [TAG_BITS-1:0] in_tag_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [KEY_BITS-1:0] out_key_out,
  output logic [TAG_BITS-1:0] out_tag_out,
  output logic [CNT_W-1:0]    out_count_out
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_GET,
    S_SCAN,
    S_RM_GET,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_RESULT
  } state_t;

  state_t              state_r;
  cnt_t                count_r;
  idx_t                pos_r;
  entry_t              cur_r;
  op_e                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic                moved_r;
  cnt_t                scan_idx_r;
  idx_t                cmp_idx_r;
  logic                cmp_v_r;
  status_e             res_status_r;
  logic [KEY_BITS-1:0] res_key_r;
  logic [TAG_BITS-1:0] res_tag_r;

  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [TAG_BITS-1:0] out_tag_r;
  cnt_t                out_count_r;

  entry_t mem [CAPACITY];
  entry_t rd_a_r;
  entry_t rd_b_r;
  idx_t   rd_addr_a;
  idx_t   rd_addr_b;
  logic   wr_en;
  idx_t   wr_addr;
  entry_t wr_data;

  logic [CHD_W-1:0]    child_l;
  logic [CHD_W-1:0]    child_r;
  logic                l_gt;
  logic                r_gt;
  logic [KEY_BITS-1:0] best_key;
  logic                dn_move;
  idx_t                dn_child;
  entry_t              dn_data;
  logic                dn_end;
  idx_t                parent;
  logic                up_gt;
  logic                scan_hit;
  idx_t                last_idx;
  logic                up_after_dn;

  // Shared compare unit: children against the moving entry, or parent against it.
  always_comb begin
    child_l     = {1'b0, pos_r, 1'b1};
    child_r     = child_l + CHD_W'(1);
    l_gt        = (child_l < CHD_W'(count_r)) && (rd_a_r.key > cur_r.key);
    best_key    = l_gt ? rd_a_r.key : cur_r.key;
    r_gt        = (child_r < CHD_W'(count_r)) && (rd_b_r.key > best_key);
    dn_move     = l_gt || r_gt;
    dn_child    = r_gt ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
    dn_data     = r_gt ? rd_b_r : rd_a_r;
    dn_end      = CHD_W'(pos_r) >= CHD_W'(count_r);
    parent      = (pos_r - idx_t'(1)) >> 1;
    up_gt       = cur_r.key > rd_a_r.key;
    scan_hit    = cmp_v_r && (rd_a_r.key == key_r);
    last_idx    = idx_t'(count_r - cnt_t'(1));
    up_after_dn = (op_r == OP_REMOVE) && !moved_r;
  end

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = last_idx;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = cur_r;
    unique case (state_r)
      S_SCAN: begin
        rd_addr_a = scan_idx_r[IDX_W-1:0];
      end
      S_DN_RD: begin
        rd_addr_a = child_l[IDX_W-1:0];
        rd_addr_b = child_r[IDX_W-1:0];
        wr_en     = dn_end;
      end
      S_DN_CMP: begin
        if (dn_move) begin
          wr_en   = 1'b1;
          wr_data = dn_data;
        end else begin
          wr_en = !up_after_dn;
        end
      end
      S_UP_RD: begin
        rd_addr_a = parent;
        wr_en     = (pos_r == '0);
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_gt ? rd_a_r : cur_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_RESULT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= op_e'(in_opcode);
            key_r        <= in_key_in;
            res_status_r <= ST_OK;
            res_key_r    <= '0;
            res_tag_r    <= '0;
            moved_r      <= 1'b0;
            scan_idx_r   <= '0;
            cmp_v_r      <= 1'b0;
            unique case (op_e'(in_opcode))
              OP_INSERT: begin
                if (count_r == cnt_t'(CAPACITY)) begin
                  res_status_r <= ST_OVERFLOW;
                  state_r      <= S_RESULT;
                end else begin
                  cur_r   <= '{key: in_key_in, tag: in_tag_in};
                  pos_r   <= count_r[IDX_W-1:0];
                  count_r <= count_r + cnt_t'(1);
                  state_r <= S_UP_RD;
                end
              end
              OP_EXTRACT: begin
                if (count_r == '0) begin
                  res_status_r <= ST_UNDERFLOW;
                  state_r      <= S_RESULT;
                end else begin
                  count_r <= count_r - cnt_t'(1);
                  pos_r   <= '0;
                  state_r <= S_EX_GET;
                end
              end
              OP_REMOVE: begin
                state_r <= S_SCAN;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_EX_GET: begin
          res_key_r <= rd_a_r.key;
          res_tag_r <= rd_a_r.tag;
          cur_r     <= rd_b_r;
          state_r   <= S_DN_RD;
        end
        S_SCAN: begin
          // One read is issued per cycle; the compare looks at the entry read last cycle.
          priority if (scan_hit) begin
            pos_r   <= cmp_idx_r;
            count_r <= count_r - cnt_t'(1);
            state_r <= S_RM_GET;
          end else if (scan_idx_r < count_r) begin
            cmp_v_r    <= 1'b1;
            cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
            scan_idx_r <= scan_idx_r + cnt_t'(1);
          end else begin
            res_status_r <= ST_NOT_FOUND;
            state_r      <= S_RESULT;
          end
        end
        S_RM_GET: begin
          cur_r   <= rd_b_r;
          state_r <= S_DN_RD;
        end
        S_DN_RD: begin
          state_r <= dn_end ? S_RESULT : S_DN_CMP;
        end
        S_DN_CMP: begin
          priority if (dn_move) begin
            pos_r   <= dn_child;
            moved_r <= 1'b1;
            state_r <= S_DN_RD;
          end else if (up_after_dn) begin
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_RESULT;
          end
        end
        S_UP_RD: begin
          state_r <= (pos_r == '0) ? S_RESULT : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_gt) begin
            pos_r   <= parent;
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_status_r <= res_status_r;
            out_key_r    <= res_key_r;
            out_tag_r    <= res_tag_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_tag_out   = out_tag_r;
  assign out_count_out = out_count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("heap count exceeds capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && cmp_v_r |-> cnt_t'(cmp_idx_r) < count_r)
    else $error("scan compares an entry beyond the count");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && (res_status_r == ST_UNDERFLOW) |-> count_r == '0)
    else $error("underflow reported on a non-empty heap");

endmodule

/* tb/sv/binary_max_heap_priority_queue_unit_tb.sv */
`timescale 1ns / 100ps

module binary_max_heap_priority_queue_unit_tb;
  import bmhpq_pkg::*;

  // The opcode space has one code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 200;
  localparam int KEY_POOL_MAX   = 96;

  typedef struct {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } heap_op_t;

  typedef struct {
    status_e             status;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    cnt_t                count;
  } heap_reply_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode   = '0;
  logic [KEY_BITS-1:0] in_key_in   = '0;
  logic [TAG_BITS-1:0] in_tag_in   = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [1:0]          out_status;
  logic [KEY_BITS-1:0] out_key_out;
  logic [TAG_BITS-1:0] out_tag_out;
  logic [CNT_W-1:0]    out_count_out;

  binary_max_heap_priority_queue_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_key_in    (in_key_in),
    .in_tag_in    (in_tag_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_key_out  (out_key_out),
    .out_tag_out  (out_tag_out),
    .out_count_out(out_count_out)
  );

  heap_op_t            ops_to_send[$];
  heap_reply_t         replies_due[$];
  logic [KEY_BITS-1:0] inserted_keys[$];

  entry_t      model_heap[CAPACITY];
  int unsigned model_len = 0;

  int errors       = 0;
  bit in_took      = 1'b0;
  bit idle_on      = 1'b1;
  int hold_asks    = 0;
  int hold_done    = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void model_swap(int unsigned a, int unsigned b);
    entry_t e;
    e = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = e;
  endfunction

  function automatic void model_sift_down(int unsigned pos);
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    while (pos < model_len) begin
      best = pos;
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      if (lc < model_len && model_heap[lc].key > model_heap[best].key) best = lc;
      if (rc < model_len && model_heap[rc].key > model_heap[best].key) best = rc;
      if (best == pos) break;
      model_swap(pos, best);
      pos = best;
    end
  endfunction

  function automatic void model_sift_up(int unsigned pos);
    int unsigned up;
    while (pos > 0 && pos < model_len) begin
      up = (pos - 1) / 2;
      if (!(model_heap[pos].key > model_heap[up].key)) break;
      model_swap(pos, up);
      pos = up;
    end
  endfunction

  // Applies one operation to the shadow heap and returns the reply it must produce.
  function automatic heap_reply_t heap_apply(heap_op_t it);
    heap_reply_t r;
    int unsigned i;
    r.status = ST_OK;
    r.key = '0;
    r.tag = '0;
    case (it.op)
      OP_INSERT: begin
        if (model_len >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_heap[model_len].key = it.key;
          model_heap[model_len].tag = it.tag;
          model_len++;
          model_sift_up(model_len - 1);
        end
      end
      OP_EXTRACT: begin
        if (model_len == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.key = model_heap[0].key;
          r.tag = model_heap[0].tag;
          model_len--;
          model_heap[0] = model_heap[model_len];
          model_sift_down(0);
        end
      end
      OP_REMOVE: begin
        i = 0;
        while (i < model_len && model_heap[i].key != it.key) i++;
        if (i == model_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          model_len--;
          model_heap[i] = model_heap[model_len];
          model_sift_down(i);
          model_sift_up(i);
        end
      end
      default: begin
      end
    endcase
    r.count = cnt_t'(model_len);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    heap_op_t    seen;
    heap_reply_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen.op = in_opcode;
        seen.key = in_key_in;
        seen.tag = in_tag_in;
        replies_due.push_back(heap_apply(seen));
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual status %0d key %h tag %h count %0d",
                   $time, out_status, out_key_out, out_tag_out, out_count_out);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("key_out", want.key, out_key_out);
          check_field("tag_out", want.tag, out_tag_out);
          check_field("count_out", want.count, out_count_out);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("binary_max_heap_priority_queue_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A new item goes out only when the line is free or the last one was just taken.
  always @(negedge clk) begin : driver
    heap_op_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(9) == 0) begin
        send_gap <= $urandom_range(15);
        in_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        nxt = ops_to_send.pop_front();
        in_valid  <= 1'b1;
        in_opcode <= nxt.op;
        in_key_in <= nxt.key;
        in_tag_in <= nxt.tag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done  <= hold_done + 1;
      stall_left <= LONG_HOLD - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(11) == 0) begin
      stall_left <= $urandom_range(15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_op(logic [1:0] op, logic [KEY_BITS-1:0] key,
                          logic [TAG_BITS-1:0] tag);
    heap_op_t            it;
    logic [KEY_BITS-1:0] dropped;
    it.op = op;
    it.key = key;
    it.tag = tag;
    ops_to_send.push_back(it);
    if (op == OP_INSERT) begin
      inserted_keys.push_back(key);
      if (inserted_keys.size() > KEY_POOL_MAX) dropped = inserted_keys.pop_front();
    end
  endtask

  // Removes mostly name a key that was inserted recently, so most of them hit.
  task automatic queue_random(int count, int w_ins, int w_ext, int w_rem, bit narrow);
    int                  pick;
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < w_ins) op = OP_INSERT;
      else if (pick < w_ins + w_ext) op = OP_EXTRACT;
      else if (pick < w_ins + w_ext + w_rem) op = OP_REMOVE;
      else op = OP_UNUSED;
      if (narrow) begin
        key = KEY_BITS'($urandom_range(7));
        if ($urandom_range(7) == 0) key = ~key;
      end else begin
        key = KEY_BITS'($urandom);
      end
      if (op == OP_REMOVE && inserted_keys.size() != 0 && $urandom_range(4) != 0)
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      queue_op(op, key, TAG_BITS'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty heap: underflow, a remove that cannot hit, and the ignored opcode.
    queue_op(OP_EXTRACT, 16'hFFFF, 16'hFFFF);
    queue_op(OP_REMOVE, 16'h0005, 16'h0000);
    queue_op(OP_UNUSED, 16'h0000, 16'h0000);
    // Extreme keys and tags, and two equal keys with different tags.
    queue_op(OP_INSERT, 16'h0000, 16'hFFFF);
    queue_op(OP_INSERT, 16'hFFFF, 16'h0000);
    queue_op(OP_INSERT, 16'h8000, 16'h1234);
    queue_op(OP_INSERT, 16'h8000, 16'h4321);
    queue_op(OP_INSERT, 16'h0001, 16'hAAAA);
    queue_op(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_op(OP_REMOVE, 16'h7777, 16'h5555);
    queue_op(OP_REMOVE, 16'h8000, 16'h0000);
    queue_op(OP_EXTRACT, 16'h0000, 16'h0000);
    queue_op(OP_EXTRACT, 16'h0000, 16'h0000);
    queue_op(OP_REMOVE, 16'h0000, 16'h0000);
    queue_op(OP_EXTRACT, 16'h0000, 16'h0000);
    queue_op(OP_EXTRACT, 16'h0000, 16'h0000);
    // Removing the entry that sits last in the array needs no sift.
    queue_op(OP_INSERT, 16'h000A, 16'h5555);
    queue_op(OP_INSERT, 16'h0005, 16'hCCCC);
    queue_op(OP_REMOVE, 16'h0005, 16'h0000);
    queue_op(OP_REMOVE, 16'h000A, 16'h0000);
    queue_op(OP_EXTRACT, 16'h0000, 16'h0000);
    wait_drained();

    // Fill past capacity to reach overflow, then churn near the top.
    queue_random(100, 93, 3, 3, 1'b0);
    wait_drained();
    queue_random(240, 35, 25, 38, 1'b0);
    wait_drained();
    queue_random(90, 5, 90, 3, 1'b0);
    wait_drained();
    queue_random(240, 40, 30, 28, 1'b1);
    wait_drained();

    // The receiver holds off for a long stretch while items keep coming.
    hold_asks++;
    queue_random(200, 40, 30, 28, 1'b0);
    wait_drained();

    queue_random(100, 93, 3, 3, 1'b1);
    wait_drained();
    queue_random(240, 45, 10, 43, 1'b1);
    wait_drained();
    queue_random(90, 3, 95, 1, 1'b1);
    wait_drained();
    queue_random(240, 38, 28, 32, 1'b0);
    wait_drained();

    idle_on = 1'b0;
    queue_random(250, 40, 28, 30, 1'b0);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("binary_max_heap_priority_queue_unit_tb OK");
    end else begin
      $display("binary_max_heap_priority_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
